// ===== hdl/sts_pkg.sv =====
// shared types, codes and tables of the source token scanner
`default_nettype none

package sts_pkg;

   // default sizing of counters and keyword prefix
   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int KEYWORD_CHARS_DEFAULT = 6;

   // token kind codes
   typedef enum logic [4:0] {
      K_PLUS   = 5'd0,
      K_MINUS  = 5'd1,
      K_STAR   = 5'd2,
      K_COMMA  = 5'd3,
      K_LPAREN = 5'd4,
      K_RPAREN = 5'd5,
      K_SLASH  = 5'd6,
      K_LBRACE = 5'd7,
      K_RBRACE = 5'd8,
      K_ASSIGN = 5'd9,
      K_EQEQ   = 5'd10,
      K_LESS   = 5'd11,
      K_NUMBER = 5'd12,
      K_IDENT  = 5'd13,
      K_LET    = 5'd14,
      K_IF     = 5'd15,
      K_ELSE   = 5'd16,
      K_WHILE  = 5'd17,
      K_PRINT  = 5'd18,
      K_INPUT  = 5'd19,
      K_TRUE   = 5'd20,
      K_FALSE  = 5'd21,
      K_DEF    = 5'd22,
      K_RETURN = 5'd23,
      K_ERROR  = 5'd24
   } kind_type;

   // pending multi-character token, one-hot
   typedef enum logic [3:0] {
      P_NONE  = 4'b0001,
      P_EQ    = 4'b0010,
      P_NUM   = 4'b0100,
      P_IDENT = 4'b1000
   } pend_type;

   // one result beat
   typedef struct packed {
      kind_type    kind;
      logic [15:0] start;
      logic [15:0] length;
      logic [15:0] line;
      logic [7:0]  bad;
      logic        last;
   } token_type;

   // special characters
   localparam logic [7:0] CH_EQ  = 8'h3D;
   localparam logic [7:0] CH_LT  = 8'h3C;
   localparam logic [7:0] CH_NL  = 8'h0A;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_TAB = 8'h09;

   // single-character operators, in kind order
   localparam int NUM_OPS = 9;
   localparam logic [7:0] OP_CHARS [NUM_OPS] = '{
      8'h2B, 8'h2D, 8'h2A, 8'h2C, 8'h28, 8'h29, 8'h2F, 8'h7B, 8'h7D
   };

   // keywords packed first char high, with their lengths
   localparam int NUM_KEYWORDS = 10;
   localparam logic [47:0] KW_TEXT [NUM_KEYWORDS] = '{
      48'("let"), 48'("if"), 48'("else"), 48'("while"), 48'("print"),
      48'("input"), 48'("true"), 48'("false"), 48'("def"), 48'("return")
   };
   localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{
      3'd3, 3'd2, 3'd4, 3'd5, 3'd5, 3'd5, 3'd4, 3'd5, 3'd3, 3'd6
   };

   // identifier or keyword from packed prefix and full length
   function automatic kind_type word_kind(input logic [63:0] prefix,
                                          input logic [31:0] len);
      kind_type k;
      k = K_IDENT;
      for (int i = 0; i < NUM_KEYWORDS; i++) begin
         if (len == 32'(KW_LEN[i]) && prefix == 64'(KW_TEXT[i])) begin
            k = kind_type'(5'(K_LET) + 5'(i));
         end
      end
      return k;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/source_token_scanner_top.sv =====
// Source token scanner: one character per cycle in while the result queue has room, tokens out.
// Each accepted character is registered, then its token beats are written into the result queue and offered from there.
// Throughput: one character per cycle; a character that closes a run and emits
// its own token yields two beats, drained one per cycle by the result queue while
// rsp_stall is low; the input stalls while more than two beats wait in the queue.
// Reset: synchronous; offset 0, line 1, nothing pending, result queue empty.
`default_nettype none

module source_token_scanner_top #(
   parameter int POSITION_BITS = sts_pkg::POSITION_BITS_DEFAULT,
   parameter int KEYWORD_CHARS = sts_pkg::KEYWORD_CHARS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_end_of_source,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic [15:0] rsp_line_number,
   output logic [7:0]  rsp_bad_char,
   output logic        rsp_last_of_run
);
   import sts_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] ch_ff;
   logic       eos_ff;
   logic       go, room, req_take, pop;
   token_type  tok0, tok1, head;
   logic [1:0] tok_count;

   // input stage handshake
   assign go          = in_valid_ff && room;
   assign req_stall   = in_valid_ff && !room;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !go);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         ch_ff  <= req_ch;
         eos_ff <= req_end_of_source;
      end
   end

   sts_scan #(
      .POSITION_BITS (POSITION_BITS),
      .KEYWORD_CHARS (KEYWORD_CHARS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .ch        (ch_ff),
      .eos       (eos_ff),
      .tok0      (tok0),
      .tok1      (tok1),
      .tok_count (tok_count)
   );

   sts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (tok_count),
      .push0      (tok0),
      .push1      (tok1),
      .pop        (pop),
      .head       (head),
      .not_empty  (rsp_valid),
      .has_room   (room)
   );

   // result beat
   assign pop              = rsp_valid && !rsp_stall;
   assign rsp_kind         = head.kind;
   assign rsp_token_start  = head.start;
   assign rsp_token_length = head.length;
   assign rsp_line_number  = head.line;
   assign rsp_bad_char     = head.bad;
   assign rsp_last_of_run  = head.last;

endmodule

`default_nettype wire

// ===== hdl/sts_scan.sv =====
// character classifier, pending token state and token builder
`default_nettype none

module sts_scan #(
   parameter int POSITION_BITS = sts_pkg::POSITION_BITS_DEFAULT,
   parameter int KEYWORD_CHARS = sts_pkg::KEYWORD_CHARS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic [7:0]         ch,
   input  logic               eos,
   output sts_pkg::token_type tok0,
   output sts_pkg::token_type tok1,
   output logic [1:0]         tok_count
);
   import sts_pkg::*;

   localparam int PB = POSITION_BITS;
   localparam int PW = 8 * KEYWORD_CHARS;
   localparam logic [PB-1:0] CNT_MAX = '1;
   localparam logic [PB-1:0] CNT_ONE = PB'(1);

   pend_type          pend_ff, pend_in;
   logic [PB-1:0]     start_ff, start_in;
   logic [PB-1:0]     length_ff, length_in;
   logic [PW-1:0]     prefix_ff, prefix_in;
   logic [PB-1:0]     position_ff, position_in;
   logic [PB-1:0]     line_ff, line_in;

   logic              is_digit, is_alpha, is_blank, op_hit;
   kind_type          op_kind;
   logic              cont;
   logic [1:0]        n;
   token_type         slot [2];

   function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
      return (v == CNT_MAX) ? v : v + CNT_ONE;
   endfunction

   function automatic logic [15:0] clamp16(input logic [PB-1:0] v);
      return (PB > 16 && (v >> 16) != '0) ? 16'hFFFF : 16'(v);
   endfunction

   function automatic token_type make_tok(input kind_type k, input logic [PB-1:0] st,
                                          input logic [PB-1:0] len,
                                          input logic [PB-1:0] ln, input logic [7:0] bad);
      token_type t;
      t.kind   = k;
      t.start  = clamp16(st);
      t.length = clamp16(len);
      t.line   = clamp16(ln);
      t.bad    = bad;
      t.last   = 1'b0;
      return t;
   endfunction

   // token for a pending run that is being closed
   function automatic token_type close_tok(input pend_type p, input logic [PB-1:0] st,
                                           input logic [PB-1:0] len,
                                           input logic [PW-1:0] pf,
                                           input logic [PB-1:0] ln);
      token_type t;
      case (p)
         P_EQ:    t = make_tok(K_ASSIGN, st, CNT_ONE, ln, 8'd0);
         P_NUM:   t = make_tok(K_NUMBER, st, len, ln, 8'd0);
         P_IDENT: t = make_tok(word_kind(64'(pf), 32'(len)), st, len, ln, 8'd0);
         default: t = '0;
      endcase
      return t;
   endfunction

   // character classes
   always_comb begin
      is_digit = 1'b0;
      is_alpha = 1'b0;
      is_blank = 1'b0;
      case (ch) inside
         [8'h30:8'h39]:          is_digit = 1'b1;
         [8'h41:8'h5A], [8'h61:8'h7A]: is_alpha = 1'b1;
         CH_SP, CH_CR, CH_TAB:   is_blank = 1'b1;
         default:                is_blank = 1'b0;
      endcase
      op_hit  = 1'b0;
      op_kind = K_PLUS;
      for (int i = 0; i < NUM_OPS; i++) begin
         if (ch == OP_CHARS[i]) begin
            op_hit  = 1'b1;
            op_kind = kind_type'(5'(i));
         end
      end
   end

   // one character step: close or extend, scan fresh, flush at end of source
   always_comb begin
      pend_in     = pend_ff;
      start_in    = start_ff;
      length_in   = length_ff;
      prefix_in   = prefix_ff;
      position_in = position_ff;
      line_in     = line_ff;
      n           = 2'd0;
      slot[0]     = '0;
      slot[1]     = '0;

      case (pend_ff)
         P_EQ:    cont = (ch == CH_EQ);
         P_NUM:   cont = is_digit;
         P_IDENT: cont = is_digit || is_alpha;
         default: cont = 1'b0;
      endcase

      // pending token: extend or close
      if (pend_ff != P_NONE) begin
         if (cont) begin
            if (pend_ff == P_EQ) begin
               slot[n[0]] = make_tok(K_EQEQ, start_ff, PB'(2), line_ff, 8'd0);
               n          = n + 2'd1;
               pend_in    = P_NONE;
               length_in  = '0;
            end else begin
               if (pend_ff == P_IDENT && length_ff < PB'(KEYWORD_CHARS)) begin
                  prefix_in = {prefix_ff[PW-9:0], ch};
               end
               length_in = sat_inc(length_ff);
            end
         end else begin
            slot[n[0]] = close_tok(pend_ff, start_ff, length_ff, prefix_ff, line_ff);
            n          = n + 2'd1;
            pend_in    = P_NONE;
            length_in  = '0;
            prefix_in  = '0;
         end
      end

      // character not absorbed by a run
      if (!cont) begin
         if (op_hit) begin
            slot[n[0]] = make_tok(op_kind, position_ff, CNT_ONE, line_ff, 8'd0);
            n          = n + 2'd1;
         end else if (ch == CH_EQ || is_digit || is_alpha) begin
            pend_in   = (ch == CH_EQ) ? P_EQ : (is_digit ? P_NUM : P_IDENT);
            start_in  = position_ff;
            length_in = CNT_ONE;
            prefix_in = is_alpha ? PW'(ch) : '0;
         end else if (ch == CH_LT) begin
            slot[n[0]] = make_tok(K_LESS, position_ff, CNT_ONE, line_ff, 8'd0);
            n          = n + 2'd1;
         end else if (ch == CH_NL) begin
            line_in = sat_inc(line_ff);
         end else if (!is_blank) begin
            slot[n[0]] = make_tok(K_ERROR, position_ff, CNT_ONE, line_ff, ch);
            n          = n + 2'd1;
         end
      end

      // end of source flushes and restarts at offset 0, line 1
      if (eos) begin
         if (pend_in != P_NONE) begin
            slot[n[0]] = close_tok(pend_in, start_in, length_in, prefix_in, line_in);
            n          = n + 2'd1;
         end
         pend_in     = P_NONE;
         start_in    = '0;
         length_in   = '0;
         prefix_in   = '0;
         position_in = '0;
         line_in     = CNT_ONE;
      end else begin
         position_in = sat_inc(position_ff);
      end

      // mark final beat of this character
      if (n == 2'd1) begin
         slot[0].last = 1'b1;
      end else if (n == 2'd2) begin
         slot[1].last = 1'b1;
      end
   end

   assign tok0      = slot[0];
   assign tok1      = slot[1];
   assign tok_count = go ? n : 2'd0;

   // scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= P_NONE;
         start_ff    <= '0;
         length_ff   <= '0;
         prefix_ff   <= '0;
         position_ff <= '0;
         line_ff     <= CNT_ONE;
      end else if (go) begin
         pend_ff     <= pend_in;
         start_ff    <= start_in;
         length_ff   <= length_in;
         prefix_ff   <= prefix_in;
         position_ff <= position_in;
         line_ff     <= line_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/sts_queue.sv =====
// four-entry result queue taking up to two beats per cycle
`default_nettype none

module sts_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         push_count,
   input  sts_pkg::token_type push0,
   input  sts_pkg::token_type push1,
   input  logic               pop,
   output sts_pkg::token_type head,
   output logic               not_empty,
   output logic               has_room
);
   import sts_pkg::*;

   token_type   entry_ff [4];
   logic [1:0]  wr_ff, wr_in;
   logic [1:0]  rd_ff, rd_in;
   logic [2:0]  count_ff, count_in;
   logic [1:0]  wr_next;

   // pointer and fill bookkeeping
   always_comb begin
      wr_next  = wr_ff + 2'd1;
      wr_in    = wr_ff + push_count;
      rd_in    = rd_ff + 2'(pop);
      count_in = count_ff + 3'(push_count) - 3'(pop);
   end

   assign head      = entry_ff[rd_ff];
   assign not_empty = (count_ff != 3'd0);
   assign has_room  = (count_ff <= 3'd2);

   // entry storage
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_next] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== tb/tb_source_token_scanner_top.sv =====
// testbench: streamed characters into the source token scanner, tokens checked against a predictor
`timescale 1ns / 1ps

module tb_source_token_scanner_top;
   import sts_pkg::*;

   localparam int WORD_HEAD_CHARS = KEYWORD_CHARS_DEFAULT;

   // one character beat waiting to be sent; drain holds it until all tokens are back
   typedef struct packed {
      logic [7:0] ch;
      logic       eos;
      logic       drain;
   } char_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_ch = 8'd0;
   logic        req_end_of_source = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [4:0]  rsp_kind;
   logic [15:0] rsp_token_start;
   logic [15:0] rsp_token_length;
   logic [15:0] rsp_line_number;
   logic [7:0]  rsp_bad_char;
   logic        rsp_last_of_run;

   source_token_scanner_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_ch            (req_ch),
      .req_end_of_source (req_end_of_source),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_token_start   (rsp_token_start),
      .rsp_token_length  (rsp_token_length),
      .rsp_line_number   (rsp_line_number),
      .rsp_bad_char      (rsp_bad_char),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   // clock and the single reset
   initial forever #1 clock = ~clock;

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   char_beat_type pending_beats [$];
   logic [7:0]  source_text [$];
   token_type   expected_tokens [$];
   token_type   step_out [2];
   int          step_count;
   token_type   want;
   char_beat_type beat;
   int          mismatches = 0;
   int          tokens_seen = 0;
   int unsigned cycle_no = 0;
   logic        drained = 1'b1;
   wire         calm = (cycle_no >= 800 && cycle_no < 1600);

   string word_list [10] = '{"let", "if", "else", "while", "print",
                             "input", "true", "false", "def", "return"};
   string op_text = "+-*,()/{}";
   string punct_text = "!\"#$%&'.:;>?@[\\]^_`|~";

   // scanner state as the predictor sees it
   pend_type    held_kind;
   logic [15:0] held_start;
   logic [15:0] held_len;
   logic [47:0] word_head;
   logic [15:0] char_pos;
   logic [15:0] line_cnt;

   task automatic report_mismatch(input string what);
      if (mismatches < 40) $display("mismatch: %s", what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] exp_val);
      if (got !== exp_val)
         report_mismatch($sformatf("token %0d %s got %0d want %0d",
                                   tokens_seen, name, got, exp_val));
   endtask

   // ---------------------------------------------------------------- predictor

   function automatic logic [15:0] bump(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic void clear_scanner();
      held_kind = P_NONE;
      held_start = 16'd0;
      held_len = 16'd0;
      word_head = 48'd0;
      char_pos = 16'd0;
      line_cnt = 16'd1;
   endfunction

   function automatic void push_token(input kind_type k, input logic [15:0] from,
                                      input logic [15:0] len, input logic [7:0] bad);
      token_type t;
      t.kind = k;
      t.start = from;
      t.length = len;
      t.line = line_cnt;
      t.bad = bad;
      t.last = 1'b0;
      step_out[step_count] = t;
      step_count++;
   endfunction

   function automatic kind_type word_token(input logic [47:0] head, input logic [15:0] len);
      kind_type k;
      k = K_IDENT;
      if (len == 16'd3 && head == "let") k = K_LET;
      if (len == 16'd2 && head == "if") k = K_IF;
      if (len == 16'd4 && head == "else") k = K_ELSE;
      if (len == 16'd5 && head == "while") k = K_WHILE;
      if (len == 16'd5 && head == "print") k = K_PRINT;
      if (len == 16'd5 && head == "input") k = K_INPUT;
      if (len == 16'd4 && head == "true") k = K_TRUE;
      if (len == 16'd5 && head == "false") k = K_FALSE;
      if (len == 16'd3 && head == "def") k = K_DEF;
      if (len == 16'd6 && head == "return") k = K_RETURN;
      return k;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   // emit whatever multi-character token is open, then forget it
   function automatic void close_held();
      case (held_kind)
         P_EQ:    push_token(K_ASSIGN, held_start, 16'd1, 8'd0);
         P_NUM:   push_token(K_NUMBER, held_start, held_len, 8'd0);
         P_IDENT: push_token(word_token(word_head, held_len), held_start, held_len, 8'd0);
         default: ;
      endcase
      held_kind = P_NONE;
      held_len = 16'd0;
      word_head = 48'd0;
   endfunction

   function automatic void open_held(input pend_type k, input logic [15:0] pos,
                                     input logic [7:0] c);
      held_kind = k;
      held_start = pos;
      held_len = 16'd1;
      word_head = (k == P_IDENT) ? {40'd0, c} : 48'd0;
   endfunction

   // character seen with nothing open that could take it
   function automatic void scan_fresh(input logic [7:0] c, input logic [15:0] pos);
      case (c)
         "+": push_token(K_PLUS, pos, 16'd1, 8'd0);
         "-": push_token(K_MINUS, pos, 16'd1, 8'd0);
         "*": push_token(K_STAR, pos, 16'd1, 8'd0);
         ",": push_token(K_COMMA, pos, 16'd1, 8'd0);
         "(": push_token(K_LPAREN, pos, 16'd1, 8'd0);
         ")": push_token(K_RPAREN, pos, 16'd1, 8'd0);
         "/": push_token(K_SLASH, pos, 16'd1, 8'd0);
         "{": push_token(K_LBRACE, pos, 16'd1, 8'd0);
         "}": push_token(K_RBRACE, pos, 16'd1, 8'd0);
         CH_EQ: open_held(P_EQ, pos, c);
         CH_LT: push_token(K_LESS, pos, 16'd1, 8'd0);
         CH_SP, CH_CR, CH_TAB: ;
         CH_NL: line_cnt = bump(line_cnt);
         default: begin
            if (is_digit(c)) open_held(P_NUM, pos, c);
            else if (is_letter(c)) open_held(P_IDENT, pos, c);
            else push_token(K_ERROR, pos, 16'd1, c);
         end
      endcase
   endfunction

   // one accepted character: queue up the tokens it should produce
   function automatic void scan_char(input logic [7:0] c, input logic eos);
      logic [15:0] pos;
      logic        taken;
      token_type   t;
      pos = char_pos;
      taken = 1'b0;
      step_count = 0;
      case (held_kind)
         P_EQ: begin
            if (c == CH_EQ) begin
               push_token(K_EQEQ, held_start, 16'd2, 8'd0);
               held_kind = P_NONE;
               held_len = 16'd0;
               taken = 1'b1;
            end else begin
               close_held();
            end
         end
         P_NUM: begin
            if (is_digit(c)) begin
               held_len = bump(held_len);
               taken = 1'b1;
            end else begin
               close_held();
            end
         end
         P_IDENT: begin
            if (is_digit(c) || is_letter(c)) begin
               if (held_len < WORD_HEAD_CHARS) word_head = {word_head[39:0], c};
               held_len = bump(held_len);
               taken = 1'b1;
            end else begin
               close_held();
            end
         end
         default: ;
      endcase
      if (!taken) scan_fresh(c, pos);
      if (eos) begin
         close_held();
         clear_scanner();
      end else begin
         char_pos = bump(char_pos);
      end
      for (int i = 0; i < step_count; i++) begin
         t = step_out[i];
         t.last = (i == step_count - 1);
         expected_tokens = {expected_tokens, t};
      end
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic void put_char(input logic [7:0] c);
      source_text = {source_text, c};
   endfunction

   function automatic void put_text(input string s);
      for (int i = 0; i < s.len(); i++) source_text = {source_text, s[i]};
   endfunction

   // move the built source into the send queue, end of source on its last character
   function automatic void flush_source(input logic drain);
      char_beat_type b;
      for (int i = 0; i < source_text.size(); i++) begin
         b.ch = source_text[i];
         b.eos = (i == source_text.size() - 1);
         b.drain = drain && (i == 0);
         pending_beats = {pending_beats, b};
      end
      source_text.delete();
   endfunction

   function automatic logic [7:0] rand_letter();
      return ($urandom_range(1) == 0) ? 8'("a") + 8'($urandom_range(25))
                                      : 8'("A") + 8'($urandom_range(25));
   endfunction

   function automatic logic [7:0] rand_alnum();
      return ($urandom_range(2) == 0) ? 8'("0") + 8'($urandom_range(9)) : rand_letter();
   endfunction

   function automatic logic [7:0] rand_blank();
      case ($urandom_range(3))
         0: return CH_SP;
         1: return CH_TAB;
         2: return CH_CR;
         default: return CH_NL;
      endcase
   endfunction

   // a byte the scanner has no class for
   function automatic logic [7:0] rand_bad();
      logic [7:0] c;
      case ($urandom_range(3))
         0: begin
            c = 8'($urandom_range(12));
            if (c == CH_TAB || c == CH_NL) c = 8'd11;
         end
         1: c = 8'($urandom_range(31, 14));
         2: c = punct_text[$urandom_range(punct_text.len() - 1)];
         default: c = 8'($urandom_range(255, 127));
      endcase
      return c;
   endfunction

   function automatic void add_token();
      int    pick;
      int    n;
      string w;
      pick = $urandom_range(99);
      if (pick < 18) begin
         put_text(word_list[$urandom_range(9)]);
      end else if (pick < 28) begin
         // near misses of a keyword: short by one, one too long, capitalized
         w = word_list[$urandom_range(9)];
         case ($urandom_range(2))
            0: put_text(w.substr(0, w.len() - 2));
            1: begin
               put_text(w);
               put_char(rand_alnum());
            end
            default: begin
               put_char(w[0] - 8'd32);
               put_text(w.substr(1, w.len() - 1));
            end
         endcase
      end else if (pick < 45) begin
         put_char(rand_letter());
         n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(7);
         repeat (n) put_char(rand_alnum());
      end else if (pick < 57) begin
         repeat ($urandom_range(8, 1)) put_char(8'("0") + 8'($urandom_range(9)));
      end else if (pick < 72) begin
         put_char(op_text[$urandom_range(8)]);
      end else if (pick < 82) begin
         case ($urandom_range(2))
            0: put_char(CH_EQ);
            1: put_text("==");
            default: put_char(CH_LT);
         endcase
      end else if (pick < 94) begin
         repeat ($urandom_range(3, 1)) put_char(rand_blank());
      end else begin
         put_char(rand_bad());
      end
   endfunction

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_beats.size() == 0 || (!calm && $urandom_range(99) < 16)
             || (pending_beats[0].drain && (req_valid || !drained))) begin
            req_valid <= 1'b0;
         end else begin
            beat = pending_beats.pop_front();
            req_valid <= 1'b1;
            req_ch <= beat.ch;
            req_end_of_source <= beat.eos;
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
      if (reset) begin
         clear_scanner();
         rsp_stall <= 1'b0;
         drained <= 1'b1;
      end else begin
         // predict first so a same-edge token never races its expectation
         if (req_valid && !req_stall) scan_char(req_ch, req_end_of_source);
         if (rsp_valid && !rsp_stall) begin
            if (expected_tokens.size() == 0) begin
               report_mismatch($sformatf("token %0d kind %0d start %0d with none expected",
                                         tokens_seen, rsp_kind, rsp_token_start));
            end else begin
               want = expected_tokens.pop_front();
               check_field("kind", 16'(rsp_kind), 16'(want.kind));
               check_field("start", rsp_token_start, want.start);
               check_field("length", rsp_token_length, want.length);
               check_field("line", rsp_line_number, want.line);
               check_field("bad_char", 16'(rsp_bad_char), 16'(want.bad));
               check_field("last_of_run", 16'(rsp_last_of_run), 16'(want.last));
            end
            tokens_seen++;
         end
         drained <= (expected_tokens.size() == 0);
         rsp_stall <= !calm && ($urandom_range(99) < 16);
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      int target;
      int sources;
      sources = 0;

      // directed: identifier with digits, '=' closed by '<', every operator, '==',
      // newline and blanks, NUL, 0xFF, then a letter that is flushed by end of source
      put_text("if9=<+-*,()/{}==");
      put_char(CH_NL);
      put_char(CH_SP);
      put_char(CH_TAB);
      put_char(CH_CR);
      put_char(8'h00);
      put_char(8'hFF);
      put_char("z");
      flush_source(1'b0);

      for (int half = 0; half < 2; half++) begin
         target = pending_beats.size() + 940;
         while (pending_beats.size() < target) begin
            if ($urandom_range(9) == 0) begin
               // noise source of raw bytes
               repeat ($urandom_range(20, 1)) put_char(8'($urandom_range(255)));
            end else begin
               repeat ($urandom_range(25, 1)) begin
                  add_token();
                  if ($urandom_range(1) == 0) put_char(rand_blank());
               end
            end
            flush_source(sources % 12 == 0);
            sources++;
         end
      end

      while (pending_beats.size() != 0 || req_valid) @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (expected_tokens.size() != 0)
         report_mismatch($sformatf("%0d tokens never arrived", expected_tokens.size()));
      if (mismatches == 0) begin
         $display("source_token_scanner_top regression: pass");
      end else begin
         $display("source_token_scanner_top regression: fail");
      end
      $finish;
   end

   // hang guard
   initial begin
      #4_000_000;
      $display("source_token_scanner_top regression: fail");
      $finish;
   end

endmodule
